FILE: rtl/dpbp_pkg.sv
// Shared types and constants for the depth pixel back-projection core.
// Request payload structs, register indexes and raster limits; no dependencies.
package dpbp_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int CFG_IDX_W  = 4;

	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STRIDE    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_RECIPROCAL = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH       = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH       = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X        = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y        = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X     = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y     = 4'd7;

	typedef struct packed {
		logic [15:0] depth_raw;
		logic        line_end;
		logic        frame_start;
	} dpbp_in_t;

	typedef struct packed {
		logic              point_valid;
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic [23:0]       point_z;
	} dpbp_out_t;

endpackage

FILE: rtl/depth_pixel_back_projection_core.sv
// Depth pixel back-projection core: raster counters, sequencer and one shared multiplier.
// Depends on dpbp_pkg for payload structs, register indexes and raster limits.
//
// Channel  Direction  Handshake             Payload
// pix      in         pix_valid/pix_stall   dpbp_in_t  depth_raw, line_end, frame_start
// pnt      out        pnt_valid/pnt_stall   dpbp_out_t point_valid, point_x, point_y, point_z
// cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data (register write)
//
// A pixel that yields a point runs the one 32x32 multiplier seven times with its product
// registered (z, then three partial products for each of x and y). A pixel off the sampling
// grid or with zero depth goes straight to S_DONE; one out of range goes there from S_ZCHK.
// Reset clears counters, phases, sequencer and output valid, and loads register defaults.
// The output register frees the sequencer: a new pixel is taken while a result waits,
// and a finished result holds in the sequencer until the output register drains.
module depth_pixel_back_projection_core
	import dpbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  dpbp_in_t             pix_data,
	output logic                 pnt_valid,
	input  logic                 pnt_stall,
	output dpbp_out_t            pnt_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_ZMUL = 8'b0000_0010,
		S_ZCHK = 8'b0000_0100,
		S_PM   = 8'b0000_1000,
		S_PLO  = 8'b0001_0000,
		S_PHI  = 8'b0010_0000,
		S_PACC = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} seq_state_t;

	seq_state_t state_q;

	logic [4:0]  pixel_stride_q;
	logic [31:0] unit_recip_q;
	logic [23:0] min_depth_q;
	logic [23:0] max_depth_q;
	logic [19:0] center_x_q;
	logic [19:0] center_y_q;
	logic [31:0] inv_fx_q;
	logic [31:0] inv_fy_q;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [3:0]       cph_q;
	logic [3:0]       rph_q;

	logic [15:0] raw_q;
	logic [19:0] mag_x_q;
	logic [19:0] mag_y_q;
	logic        neg_x_q;
	logic        neg_y_q;
	logic [23:0] z_q;
	logic        pt_ok_q;
	logic        coord_q;
	logic [11:0] mhi_q;
	logic [64:0] lo_q;
	logic [63:0] prod_q;
	logic signed [23:0] x_q;
	logic signed [23:0] y_q;
	logic        out_valid_q;
	dpbp_out_t   out_q;

	logic             accept;
	logic [4:0]       stride_e;
	logic [COL_W-1:0] col_e;
	logic [ROW_W-1:0] row_e;
	logic [3:0]       cph_e;
	logic [3:0]       rph_e;
	logic [COL_W-1:0] col_n;
	logic [ROW_W-1:0] row_n;
	logic [3:0]       cph_n;
	logic [3:0]       rph_n;
	logic             cand;
	logic [19:0]      pos_x;
	logic [19:0]      pos_y;
	logic [31:0]      mul_a;
	logic [31:0]      mul_b;
	logic [19:0]      mag_sel;
	logic [31:0]      inv_sel;
	logic             neg_sel;
	logic [48:0]      z_sum;
	logic [32:0]      z_full;
	logic             z_ok;
	logic [76:0]      total;
	logic [36:0]      r_mag;
	logic [23:0]      r_sat;
	logic             load_out;

	assign cfg_ready = 1'b1;
	assign pix_stall = (state_q != S_IDLE);
	assign accept    = pix_valid && !pix_stall;
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || !pnt_stall);
	assign pnt_valid = out_valid_q;
	assign pnt_data  = out_q;

	always_comb begin
		if (pixel_stride_q == 5'd0) begin
			stride_e = 5'd1;
		end else if (pixel_stride_q > 5'd16) begin
			stride_e = 5'd16;
		end else begin
			stride_e = pixel_stride_q;
		end
		col_e = pix_data.frame_start ? '0 : col_q;
		row_e = pix_data.frame_start ? '0 : row_q;
		cph_e = pix_data.frame_start ? 4'd0 : cph_q;
		rph_e = pix_data.frame_start ? 4'd0 : rph_q;
		cand  = (cph_e == 4'd0) && (rph_e == 4'd0) && (pix_data.depth_raw != 16'd0);
		pos_x = 20'({col_e, 8'h00});
		pos_y = 20'({row_e, 8'h00});
		col_n = col_e;
		row_n = row_e;
		cph_n = cph_e;
		rph_n = rph_e;
		if (pix_data.line_end) begin
			col_n = '0;
			cph_n = 4'd0;
			if (row_e < ROW_W'(MAX_HEIGHT - 1)) begin
				row_n = row_e + ROW_W'(1);
				rph_n = (({1'b0, rph_e} + 5'd1) >= stride_e) ? 4'd0 : (rph_e + 4'd1);
			end
		end else if (col_e < COL_W'(MAX_WIDTH - 1)) begin
			col_n = col_e + COL_W'(1);
			cph_n = (({1'b0, cph_e} + 5'd1) >= stride_e) ? 4'd0 : (cph_e + 4'd1);
		end
	end

	always_comb begin
		mag_sel = coord_q ? mag_y_q : mag_x_q;
		inv_sel = coord_q ? inv_fy_q : inv_fx_q;
		neg_sel = coord_q ? neg_y_q : neg_x_q;
		case (state_q)
			S_ZMUL: begin
				mul_a = {16'd0, raw_q};
				mul_b = unit_recip_q;
			end
			S_PM: begin
				mul_a = {12'd0, mag_sel};
				mul_b = {8'd0, z_q};
			end
			S_PLO: begin
				mul_a = prod_q[31:0];
				mul_b = inv_sel;
			end
			S_PHI: begin
				mul_a = {20'd0, mhi_q};
				mul_b = inv_sel;
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	always_comb begin
		z_sum  = {1'b0, prod_q[47:0]} + 49'h8000;
		z_full = z_sum[48:16];
		z_ok   = (z_full >= {9'd0, min_depth_q}) && (z_full <= {9'd0, max_depth_q});
		total  = {12'd0, lo_q} + {1'b0, prod_q[43:0], 32'd0};
		r_mag  = total[76:40];
		if (neg_sel) begin
			r_sat = (r_mag > 37'd8388608) ? 24'h800000 : (24'd0 - r_mag[23:0]);
		end else begin
			r_sat = (r_mag > 37'd8388607) ? 24'h7FFFFF : r_mag[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_stride_q <= 5'd2;
			unit_recip_q   <= 32'd4294967;
			min_depth_q    <= 24'd13107;
			max_depth_q    <= 24'd524288;
			center_x_q     <= 20'd82188;
			center_y_q     <= 20'd62323;
			inv_fx_q       <= 32'd11091537;
			inv_fy_q       <= 32'd11091537;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PIXEL_STRIDE:    pixel_stride_q <= cfg_data[4:0];
				REG_UNIT_RECIPROCAL: unit_recip_q   <= cfg_data;
				REG_MIN_DEPTH:       min_depth_q    <= cfg_data[23:0];
				REG_MAX_DEPTH:       max_depth_q    <= cfg_data[23:0];
				REG_CENTER_X:        center_x_q     <= cfg_data[19:0];
				REG_CENTER_Y:        center_y_q     <= cfg_data[19:0];
				REG_INV_FOCAL_X:     inv_fx_q       <= cfg_data;
				REG_INV_FOCAL_Y:     inv_fy_q       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			cph_q       <= 4'd0;
			rph_q       <= 4'd0;
			pt_ok_q     <= 1'b0;
			coord_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!pnt_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						col_q   <= col_n;
						row_q   <= row_n;
						cph_q   <= cph_n;
						rph_q   <= rph_n;
						pt_ok_q <= 1'b0;
						coord_q <= 1'b0;
						state_q <= cand ? S_ZMUL : S_DONE;
					end
				end
				S_ZMUL: state_q <= S_ZCHK;
				S_ZCHK: begin
					pt_ok_q <= z_ok;
					state_q <= z_ok ? S_PM : S_DONE;
				end
				S_PM:  state_q <= S_PLO;
				S_PLO: state_q <= S_PHI;
				S_PHI: state_q <= S_PACC;
				S_PACC: begin
					coord_q <= 1'b1;
					state_q <= coord_q ? S_DONE : S_PM;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			raw_q   <= pix_data.depth_raw;
			neg_x_q <= pos_x < center_x_q;
			neg_y_q <= pos_y < center_y_q;
			mag_x_q <= (pos_x < center_x_q) ? (center_x_q - pos_x) : (pos_x - center_x_q);
			mag_y_q <= (pos_y < center_y_q) ? (center_y_q - pos_y) : (pos_y - center_y_q);
		end
		if (state_q == S_ZCHK) begin
			z_q <= z_full[23:0];
		end
		if (state_q == S_PLO) begin
			mhi_q <= prod_q[43:32];
		end
		if (state_q == S_PHI) begin
			lo_q <= {1'b0, prod_q} + 65'h80_0000_0000;
		end
		if (state_q == S_PACC) begin
			if (coord_q) begin
				y_q <= r_sat;
			end else begin
				x_q <= r_sat;
			end
		end
		if (load_out) begin
			out_q.point_valid <= pt_ok_q;
			out_q.point_x     <= pt_ok_q ? x_q : 24'sd0;
			out_q.point_y     <= pt_ok_q ? y_q : 24'sd0;
			out_q.point_z     <= pt_ok_q ? z_q : 24'd0;
		end
	end

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pnt_valid && !pnt_data.point_valid |->
			pnt_data.point_x == 24'sd0 && pnt_data.point_y == 24'sd0
			&& pnt_data.point_z == 24'd0)
		else $error("invalid point carries nonzero coordinates");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall |=> pix_stall)
		else $error("sequencer free right after a request");

	a_frame_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall && pix_data.frame_start && !pix_data.line_end |=>
			row_q == '0 && col_q == COL_W'(1))
		else $error("frame start did not restart the counters");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && !out_valid_q |=> pnt_valid && state_q == S_IDLE)
		else $error("finished result not moved to output register");

endmodule
